[rtl/olist_pkg.sv]
package olist_pkg;

	localparam int DATA_W = 32;
	localparam int POS_W  = 5;
	localparam int CMD_W  = 3;
	localparam int STAT_W = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_INSERT     = 3'd4,
		CMD_DUMP       = 3'd5
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK     = 2'd0,
		STAT_FULL   = 2'd1,
		STAT_EMPTY  = 2'd2,
		STAT_BADPOS = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_TAKE_PREV,
		CELL_TAKE_NEXT,
		CELL_TAKE_HEAD
	} cell_op_t;

	typedef enum logic {
		ST_IDLE,
		ST_DUMP
	} state_t;

endpackage

[rtl/olist_cell.sv]
module olist_cell (
	input  logic                           clk,
	input  olist_pkg::cell_op_t            op,
	input  logic [olist_pkg::DATA_W-1:0]   load_data,
	input  logic [olist_pkg::DATA_W-1:0]   prev_data,
	input  logic [olist_pkg::DATA_W-1:0]   next_data,
	input  logic [olist_pkg::DATA_W-1:0]   head_data,
	output logic [olist_pkg::DATA_W-1:0]   data
);

	logic [olist_pkg::DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		case (op)
			olist_pkg::CELL_LOAD:      data_q <= load_data;
			olist_pkg::CELL_TAKE_PREV: data_q <= prev_data;
			olist_pkg::CELL_TAKE_NEXT: data_q <= next_data;
			olist_pkg::CELL_TAKE_HEAD: data_q <= head_data;
			default:                   data_q <= data_q;
		endcase
	end

	assign data = data_q;

endmodule

[rtl/ordered_list_engine.sv]
// Ordered list of up to CAPACITY signed 32-bit values held in a row of cells.
// Input channel s_axis: one command per beat. tuser carries the command code,
// tdata carries the value (bits 31:0) and the insert position (bits 36:32).
// Output channel m_axis: one beat per result. tuser carries the status,
// tdata the dumped element (zero on edit results), tlast marks the final beat
// of a command.
// Push, pop and insert shift or load the affected cells in parallel in the
// accepting cycle and present their single result in the next cycle: one
// command per cycle while the output is taken.
// A dump of N elements emits N beats, one per cycle while the output is taken,
// by rotating the cells towards the front; after N steps the list is back in
// its original order. No command is accepted during a dump. Codes 6 and 7 are
// taken and dropped. A stalled receiver holds the output beat; the next command
// is accepted only once the output register is free or being emptied in the same cycle.
// Reset empties the list and clears the output valid; cell contents are not
// cleared, only cells below the count are ever read.
module ordered_list_engine #(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // value[31:0], position[36:32], zero[39:37]
	input  logic [2:0]  s_axis_tuser,  // command[2:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // element[31:0]
	output logic [1:0]  m_axis_tuser,  // status[1:0]
	output logic        m_axis_tlast
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > olist_pkg::POS_W) ? CW : olist_pkg::POS_W;

	olist_pkg::state_t   state_q, state_next;
	logic [CW-1:0]       count_q, count_next;
	logic [CW-1:0]       idx_q, idx_next;
	logic                out_free, s_fire, out_load;
	logic                full, empty, dump_step;
	olist_pkg::cmd_t     cmd;
	logic [31:0]         value;
	logic [PW-1:0]       pos_w, count_w;
	olist_pkg::status_t  out_status;
	logic [31:0]         out_element;
	logic                out_last;
	logic [1:0]          m_status_q;
	logic [31:0]         m_element_q;
	logic                m_last_q, m_valid_q;

	logic [olist_pkg::DATA_W-1:0] cell_data [CAPACITY];
	olist_pkg::cell_op_t          cell_op   [CAPACITY];

	assign cmd      = olist_pkg::cmd_t'(s_axis_tuser);
	assign value    = s_axis_tdata[31:0];
	assign pos_w    = PW'(s_axis_tdata[36:32]);
	assign count_w  = PW'(count_q);
	assign full     = (count_q == CW'(CAPACITY));
	assign empty    = (count_q == '0);
	assign out_free = !m_valid_q || m_axis_tready;
	assign s_fire   = s_axis_tvalid && s_axis_tready;

	genvar g;
	generate
		for (g = 0; g < CAPACITY; g++) begin : g_cell
			logic [olist_pkg::DATA_W-1:0] prev_d, next_d;
			if (g == 0) begin : g_first
				assign prev_d = cell_data[g];
			end else begin : g_prev
				assign prev_d = cell_data[g-1];
			end
			if (g == CAPACITY - 1) begin : g_last
				assign next_d = cell_data[g];
			end else begin : g_next
				assign next_d = cell_data[g+1];
			end
			olist_cell u_cell (
				.clk       (clk),
				.op        (cell_op[g]),
				.load_data (value),
				.prev_data (prev_d),
				.next_data (next_d),
				.head_data (cell_data[0]),
				.data      (cell_data[g])
			);
		end
	endgenerate

	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			cell_op[i] = olist_pkg::CELL_HOLD;
			if (s_fire) begin
				case (cmd)
					olist_pkg::CMD_PUSH_FRONT: begin
						if (!full)
							cell_op[i] = (i == 0) ? olist_pkg::CELL_LOAD
							                      : olist_pkg::CELL_TAKE_PREV;
					end
					olist_pkg::CMD_PUSH_BACK: begin
						if (!full && CW'(i) == count_q)
							cell_op[i] = olist_pkg::CELL_LOAD;
					end
					olist_pkg::CMD_POP_FRONT: begin
						if (!empty && i < CAPACITY - 1)
							cell_op[i] = olist_pkg::CELL_TAKE_NEXT;
					end
					olist_pkg::CMD_INSERT: begin
						if (!full && pos_w <= count_w) begin
							if (PW'(i) == pos_w)
								cell_op[i] = olist_pkg::CELL_LOAD;
							else if (PW'(i) > pos_w)
								cell_op[i] = olist_pkg::CELL_TAKE_PREV;
						end
					end
					default: cell_op[i] = olist_pkg::CELL_HOLD;
				endcase
			end else if (dump_step) begin
				if (CW'(i + 1) < count_q)
					cell_op[i] = olist_pkg::CELL_TAKE_NEXT;
				else if (CW'(i + 1) == count_q)
					cell_op[i] = olist_pkg::CELL_TAKE_HEAD;
			end
		end
	end

	always_comb begin
		count_next = count_q;
		if (s_fire) begin
			case (cmd)
				olist_pkg::CMD_PUSH_FRONT,
				olist_pkg::CMD_PUSH_BACK: begin
					if (!full)
						count_next = count_q + CW'(1);
				end
				olist_pkg::CMD_POP_FRONT,
				olist_pkg::CMD_POP_BACK: begin
					if (!empty)
						count_next = count_q - CW'(1);
				end
				olist_pkg::CMD_INSERT: begin
					if (!full && pos_w <= count_w)
						count_next = count_q + CW'(1);
				end
				default: count_next = count_q;
			endcase
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			olist_pkg::ST_IDLE: begin
				if (s_fire && cmd == olist_pkg::CMD_DUMP && !empty)
					state_next = olist_pkg::ST_DUMP;
			end
			olist_pkg::ST_DUMP: begin
				if (out_free && idx_q == count_q - CW'(1))
					state_next = olist_pkg::ST_IDLE;
			end
			default: state_next = olist_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		dump_step     = 1'b0;
		out_load      = 1'b0;
		out_status    = olist_pkg::STAT_OK;
		out_element   = '0;
		out_last      = 1'b1;
		idx_next      = idx_q;
		case (state_q)
			olist_pkg::ST_IDLE: begin
				s_axis_tready = out_free;
				idx_next      = '0;
				if (s_fire) begin
					case (cmd)
						olist_pkg::CMD_PUSH_FRONT,
						olist_pkg::CMD_PUSH_BACK: begin
							out_load   = 1'b1;
							out_status = full ? olist_pkg::STAT_FULL : olist_pkg::STAT_OK;
						end
						olist_pkg::CMD_POP_FRONT,
						olist_pkg::CMD_POP_BACK: begin
							out_load   = 1'b1;
							out_status = empty ? olist_pkg::STAT_EMPTY : olist_pkg::STAT_OK;
						end
						olist_pkg::CMD_INSERT: begin
							out_load = 1'b1;
							if (full)
								out_status = olist_pkg::STAT_FULL;
							else if (pos_w > count_w)
								out_status = olist_pkg::STAT_BADPOS;
						end
						olist_pkg::CMD_DUMP: begin
							if (empty) begin
								out_load   = 1'b1;
								out_status = olist_pkg::STAT_EMPTY;
							end
						end
						default: out_load = 1'b0;
					endcase
				end
			end
			olist_pkg::ST_DUMP: begin
				if (out_free) begin
					dump_step   = 1'b1;
					out_load    = 1'b1;
					out_element = cell_data[0];
					out_last    = (idx_q == count_q - CW'(1));
					idx_next    = idx_q + CW'(1);
				end
			end
			default: s_axis_tready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= olist_pkg::ST_IDLE;
			count_q   <= '0;
			idx_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			count_q <= count_next;
			idx_q   <= idx_next;
			if (out_load)
				m_valid_q <= 1'b1;
			else if (m_axis_tready)
				m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_status_q  <= out_status;
			m_element_q <= out_element;
			m_last_q    <= out_last;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_element_q;
	assign m_axis_tuser  = m_status_q;
	assign m_axis_tlast  = m_last_q;

endmodule

[verif/tb_ordered_list_engine.sv]
module tb_ordered_list_engine;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int          LIST_DEPTH     = 16;
	localparam int          CLK_PERIOD     = 20;
	localparam int          RANDOM_ITEMS   = 500;
	localparam int          CALM_TAIL      = 60;
	localparam int          HOLDOFF_AFTER  = 150;
	localparam int          HOLDOFF_CYCLES = 120;
	localparam int          DRAIN_CYCLES   = 40;
	localparam int          WATCHDOG_LIMIT = 1000;
	localparam logic [2:0]  CMD_SPARE_LO   = 3'd6;
	localparam logic [2:0]  CMD_SPARE_HI   = 3'd7;
	localparam logic [31:0] VAL_MIN        = 32'h8000_0000;
	localparam logic [31:0] VAL_MAX        = 32'h7FFF_FFFF;

	typedef struct {
		logic [2:0]         command;
		logic signed [31:0] value;
		logic [4:0]         position;
	} list_cmd_t;

	typedef struct {
		olist_pkg::status_t status;
		logic signed [31:0] element;
		logic               last;
	} list_beat_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic [2:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	list_cmd_t          pending_cmds[$];
	list_beat_t         owed_beats[$];
	logic signed [31:0] list_cells[LIST_DEPTH];
	int                 list_len = 0;
	int                 gen_len = 0;
	int                 errors = 0;
	int                 beats_seen = 0;
	int                 quiet_cycles = 0;
	bit                 calm;

	always #(CLK_PERIOD / 2) clk = ~clk;

	ordered_list_engine #(
		.CAPACITY(LIST_DEPTH)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	assign calm = pending_cmds.size() < CALM_TAIL;

	function automatic void owe_beat(olist_pkg::status_t st, logic signed [31:0] elem,
		logic lst);
		list_beat_t b;
		b.status  = st;
		b.element = elem;
		b.last    = lst;
		owed_beats = {owed_beats, b};
	endfunction

	function automatic void apply_to_list(list_cmd_t c);
		int slot;
		case (c.command)
			olist_pkg::CMD_PUSH_FRONT, olist_pkg::CMD_PUSH_BACK,
			olist_pkg::CMD_INSERT: begin
				if (c.command == olist_pkg::CMD_PUSH_FRONT)
					slot = 0;
				else if (c.command == olist_pkg::CMD_PUSH_BACK)
					slot = list_len;
				else
					slot = int'(c.position);
				if (list_len >= LIST_DEPTH) begin
					owe_beat(olist_pkg::STAT_FULL, 0, 1'b1);
				end else if (slot > list_len) begin
					owe_beat(olist_pkg::STAT_BADPOS, 0, 1'b1);
				end else begin
					for (int i = list_len; i > slot; i--)
						list_cells[i] = list_cells[i-1];
					list_cells[slot] = c.value;
					list_len++;
					owe_beat(olist_pkg::STAT_OK, 0, 1'b1);
				end
			end
			olist_pkg::CMD_POP_FRONT, olist_pkg::CMD_POP_BACK: begin
				if (list_len == 0) begin
					owe_beat(olist_pkg::STAT_EMPTY, 0, 1'b1);
				end else begin
					if (c.command == olist_pkg::CMD_POP_FRONT)
						for (int i = 0; i + 1 < list_len; i++)
							list_cells[i] = list_cells[i+1];
					list_len--;
					owe_beat(olist_pkg::STAT_OK, 0, 1'b1);
				end
			end
			olist_pkg::CMD_DUMP: begin
				if (list_len == 0)
					owe_beat(olist_pkg::STAT_EMPTY, 0, 1'b1);
				else
					for (int i = 0; i < list_len; i++)
						owe_beat(olist_pkg::STAT_OK, list_cells[i], i == list_len - 1);
			end
			default: ;
		endcase
	endfunction

	task automatic queue_cmd(logic [2:0] cmd, logic signed [31:0] val, logic [4:0] pos);
		list_cmd_t c;
		c.command  = cmd;
		c.value    = val;
		c.position = pos;
		pending_cmds = {pending_cmds, c};
		case (cmd)
			olist_pkg::CMD_PUSH_FRONT, olist_pkg::CMD_PUSH_BACK:
				if (gen_len < LIST_DEPTH) gen_len++;
			olist_pkg::CMD_INSERT:
				if (gen_len < LIST_DEPTH && pos <= gen_len) gen_len++;
			olist_pkg::CMD_POP_FRONT, olist_pkg::CMD_POP_BACK:
				if (gen_len > 0) gen_len--;
			default: ;
		endcase
	endtask

	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(0, 31))
			0: return VAL_MIN;
			1: return VAL_MAX;
			2: return 32'sd0;
			3: return -32'sd1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [4:0] pick_position();
		if ($urandom_range(0, 3) == 0)
			return 5'($urandom_range(0, 31));
		return 5'($urandom_range(0, gen_len));
	endfunction

	// driver
	list_cmd_t cur_cmd;
	int        gap_left = 0;

	always @(posedge clk) begin
		bit offer;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				apply_to_list(cur_cmd);
			offer = s_axis_tvalid && !s_axis_tready;
			if (!offer) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_cmds.size() > 0) begin
					if (!calm && $urandom_range(0, 7) == 0) begin
						gap_left = $urandom_range(0, 5);
					end else begin
						cur_cmd = pending_cmds[0];
						pending_cmds.delete(0);
						offer = 1'b1;
					end
				end
			end
			s_axis_tvalid <= offer;
			s_axis_tdata  <= {3'b000, cur_cmd.position, cur_cmd.value};
			s_axis_tuser  <= cur_cmd.command;
		end
	end

	// monitor
	int stall_left = 0;
	int hold_left = 0;
	bit held_once = 1'b0;

	always @(posedge clk) begin
		list_beat_t exp_beat;
		bit         rdy;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				beats_seen++;
				if (owed_beats.size() == 0) begin
					$error("unexpected beat: status %0d element %0d last %0d",
						m_axis_tuser, $signed(m_axis_tdata), m_axis_tlast);
					errors++;
				end else begin
					exp_beat = owed_beats[0];
					owed_beats.delete(0);
					if (m_axis_tuser !== exp_beat.status) begin
						$error("status: expected %0d, got %0d", exp_beat.status, m_axis_tuser);
						errors++;
					end
					if (m_axis_tdata !== exp_beat.element) begin
						$error("element: expected %0d, got %0d", exp_beat.element,
							$signed(m_axis_tdata));
						errors++;
					end
					if (m_axis_tlast !== exp_beat.last) begin
						$error("last: expected %0d, got %0d", exp_beat.last, m_axis_tlast);
						errors++;
					end
				end
			end
			rdy = 1'b0;
			if (hold_left > 0) begin
				hold_left--;
			end else if (!held_once && beats_seen >= HOLDOFF_AFTER) begin
				// hold off long enough for the input side to back up
				held_once = 1'b1;
				hold_left = HOLDOFF_CYCLES - 1;
			end else if (stall_left > 0) begin
				stall_left--;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 5);
			end else begin
				rdy = 1'b1;
			end
			m_axis_tready <= rdy;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		int real_items;
		int mode_left;
		bit filling;
		int pick;

		cur_cmd = '{command: CMD_SPARE_LO, value: 32'sd0, position: 5'd0};

		queue_cmd(olist_pkg::CMD_DUMP, 32'sd0, 5'd0);
		queue_cmd(olist_pkg::CMD_POP_FRONT, 32'sd0, 5'd0);
		queue_cmd(olist_pkg::CMD_POP_BACK, 32'sd0, 5'd0);
		queue_cmd(olist_pkg::CMD_INSERT, 32'sd5, 5'd1);
		queue_cmd(olist_pkg::CMD_INSERT, VAL_MIN, 5'd0);
		queue_cmd(olist_pkg::CMD_POP_BACK, 32'sd0, 5'd0);
		queue_cmd(olist_pkg::CMD_DUMP, 32'sd0, 5'd0);
		queue_cmd(olist_pkg::CMD_PUSH_BACK, VAL_MAX, 5'd0);
		queue_cmd(olist_pkg::CMD_INSERT, -32'sd1, 5'd1);
		queue_cmd(olist_pkg::CMD_INSERT, 32'sh5555_5555, 5'd1);
		queue_cmd(olist_pkg::CMD_PUSH_FRONT, 32'shAAAA_AAAA, 5'd0);
		queue_cmd(olist_pkg::CMD_DUMP, 32'sd0, 5'd0);
		queue_cmd(olist_pkg::CMD_POP_FRONT, 32'sd0, 5'd0);
		queue_cmd(olist_pkg::CMD_INSERT, 32'sd7, 5'd31);
		queue_cmd(CMD_SPARE_LO, $urandom, 5'($urandom));
		queue_cmd(CMD_SPARE_HI, $urandom, 5'($urandom));
		while (gen_len < LIST_DEPTH)
			queue_cmd(gen_len % 2 ? olist_pkg::CMD_PUSH_FRONT : olist_pkg::CMD_PUSH_BACK,
				pick_value(), 5'd0);
		queue_cmd(olist_pkg::CMD_PUSH_FRONT, 32'sd1, 5'd0);
		queue_cmd(olist_pkg::CMD_PUSH_BACK, 32'sd2, 5'd0);
		queue_cmd(olist_pkg::CMD_INSERT, 32'sd3, 5'd31);
		queue_cmd(olist_pkg::CMD_DUMP, 32'sd0, 5'd0);

		real_items = 0;
		mode_left = 0;
		filling = 1'b0;
		while (real_items < RANDOM_ITEMS) begin
			if (mode_left == 0) begin
				filling = ~filling;
				mode_left = $urandom_range(10, 40);
			end
			mode_left--;
			pick = $urandom_range(0, 99);
			if (pick < 2) begin
				queue_cmd($urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO,
					$urandom, 5'($urandom));
				continue;
			end
			real_items++;
			if (pick < (filling ? 27 : 10))
				queue_cmd(olist_pkg::CMD_PUSH_FRONT, pick_value(), 5'($urandom));
			else if (pick < (filling ? 52 : 18))
				queue_cmd(olist_pkg::CMD_PUSH_BACK, pick_value(), 5'($urandom));
			else if (pick < (filling ? 77 : 26))
				queue_cmd(olist_pkg::CMD_INSERT, pick_value(), pick_position());
			else if (pick < (filling ? 90 : 88))
				queue_cmd($urandom_range(0, 1) ? olist_pkg::CMD_POP_BACK
				                               : olist_pkg::CMD_POP_FRONT,
					$urandom, 5'($urandom));
			else
				queue_cmd(olist_pkg::CMD_DUMP, $urandom, 5'($urandom));
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		@(negedge clk);
		while (pending_cmds.size() > 0 || s_axis_tvalid || owed_beats.size() > 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (owed_beats.size() > 0) begin
			$error("%0d expected beats never arrived", owed_beats.size());
			errors++;
		end
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

[ordered_list_engine.f]
rtl/olist_pkg.sv
rtl/olist_cell.sv
rtl/ordered_list_engine.sv
verif/tb_ordered_list_engine.sv
